### rtl/ffba_pkg.sv
package ffba_pkg;

    localparam int MEM_BYTES_DEF = 256;
    localparam int CMD_W = 3;
    localparam int OFF_W = 8;
    localparam int LEN_W = 9;
    localparam int BYTE_W = 8;
    localparam int RES_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FREE    = 3'd1,
        CMD_REALLOC = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    localparam logic [RES_W-1:0] RES_OK      = 2'd0;
    localparam logic [RES_W-1:0] RES_NO_ROOM = 2'd1;
    localparam logic [RES_W-1:0] RES_BAD_OFF = 2'd2;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_INNER  = 2'd1;
    localparam logic [1:0] ST_TAG    = 2'd2;
    localparam logic [1:0] ST_SINGLE = 2'd3;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LOC,
        S_FIT,
        S_FILL,
        S_COPY,
        S_RD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FK_CLEAR_FREE,
        FK_CLEAR_RE,
        FK_MARK_NEW,
        FK_MARK_OLD
    } fill_kind_t;

endpackage

### rtl/ffba_mem.sv
module ffba_mem #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          st_we,
    input  logic [AW-1:0] st_waddr,
    input  logic [1:0]    st_wdata,
    input  logic [AW-1:0] st_raddr,
    output logic [1:0]    st_rdata,
    input  logic          dt_we,
    input  logic [AW-1:0] dt_waddr,
    input  logic [7:0]    dt_wdata,
    input  logic [AW-1:0] dt_raddr,
    output logic [7:0]    dt_rdata
);

    logic [1:0] status_mem [DEPTH];
    logic [7:0] data_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[st_waddr] <= st_wdata;
        end
        st_rdata <= status_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            data_mem[dt_waddr] <= dt_wdata;
        end
        dt_rdata <= data_mem[dt_raddr];
    end

endmodule

### rtl/first_fit_byte_allocator.sv
// First-fit byte allocator over a MEM_BYTES-deep data store.
// Input words arrive on s_tvalid/s_tready/s_tdata (command, offset, size,
// write byte); one result word per command leaves on m_tvalid/m_tready/m_tdata
// (status, granted offset, read byte).
// Alloc, free and realloc walk the status memory one entry per cycle through its
// single read port: byte access reads or writes the data store directly, alloc
// runs a first-fit scan and then marks the granted bytes, free searches for the
// block and clears its bytes, and realloc clears the old block and then adds a
// second scan, a byte copy and a mark.
// A new command is taken only when the previous one has finished its work;
// the result register lets the next command start while a result still waits.
// After reset the block clears every entry of both memories before
// it raises s_tready. If the receiver stalls, the finished result is held in
// the output register and a following command stalls at its end until the
// register is free.
module first_fit_byte_allocator #(
    parameter int MEM_BYTES = ffba_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], block_offset[10:3], request_size[19:11], write_data[27:20]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_status[1:0], granted_offset[9:2], read_data[17:10]
    output logic [23:0] m_tdata
);
    import ffba_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int CW = AW + 1;
    localparam int WW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(MEM_BYTES);

    logic [CMD_W-1:0]  in_cmd;
    logic [OFF_W-1:0]  in_off;
    logic [LEN_W-1:0]  in_len;
    logic [BYTE_W-1:0] in_wdat;
    logic              in_off_ok;
    logic              in_len_ok;
    logic              accept;

    state_t state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic pend_reg, pend_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic open_reg, open_next;
    logic hit_reg, hit_next;
    logic [CW-1:0] run_reg, run_next;
    logic [AW-1:0] st_reg, st_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [AW-1:0] off_reg, off_next;
    logic [CW-1:0] len_reg, len_next;
    logic len_ok_reg, len_ok_next;
    logic [AW-1:0] old_end_reg, old_end_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] fill_pos_reg, fill_pos_next;
    logic [AW-1:0] fill_end_reg, fill_end_next;
    logic [AW-1:0] fill_base_reg, fill_base_next;
    logic fill_mark_reg, fill_mark_next;
    fill_kind_t fill_kind_reg, fill_kind_next;
    logic [CW-1:0] cp_k_reg, cp_k_next;
    logic [CW-1:0] cp_n_reg, cp_n_next;
    logic cp_pend_reg, cp_pend_next;
    logic [AW-1:0] cp_dst_reg, cp_dst_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic [AW-1:0] grant_reg, grant_next;
    logic [BYTE_W-1:0] rdat_reg, rdat_next;
    logic out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_res_reg, out_res_next;
    logic [OFF_W-1:0] out_grant_reg, out_grant_next;
    logic [BYTE_W-1:0] out_rdat_reg, out_rdat_next;

    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [1:0]    st_wdata;
    logic [AW-1:0] st_raddr;
    logic [1:0]    st_rdata;
    logic          dt_we;
    logic [AW-1:0] dt_waddr;
    logic [7:0]    dt_wdata;
    logic [AW-1:0] dt_raddr;
    logic [7:0]    dt_rdata;

    logic scan_issue;
    logic loc_hit;
    logic scan_end;
    logic [CW-1:0] run_inc;
    logic fit_hit;
    logic [AW-1:0] fit_start;
    logic fill_last;
    logic cp_issue;
    logic copy_done;
    logic out_free;
    logic [CW-1:0] old_len;
    logic [AW-1:0] new_end;

    assign in_cmd  = s_tdata[2:0];
    assign in_off  = s_tdata[10:3];
    assign in_len  = s_tdata[19:11];
    assign in_wdat = s_tdata[27:20];
    assign in_off_ok = WW'(in_off) < WW'(MEM_BYTES);
    assign in_len_ok = (in_len != '0) && (WW'(in_len) <= WW'(MEM_BYTES));

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_rdat_reg, out_grant_reg, out_res_reg};

    assign scan_issue = (ptr_reg != DEPTH_C);
    assign scan_end = pend_reg && (idx_reg == LAST_ADDR);
    assign loc_hit = pend_reg &&
        ((st_rdata == ST_SINGLE && !open_reg && idx_reg == off_reg) ||
         (st_rdata == ST_TAG && open_reg && hit_reg));
    assign run_inc = run_reg + CW'(1);
    assign fit_hit = pend_reg && (st_rdata == ST_FREE) && (run_inc == len_reg);
    assign fit_start = (run_reg == '0) ? idx_reg : st_reg;
    assign fill_last = (fill_pos_reg == fill_end_reg);
    assign cp_issue = (cp_k_reg != cp_n_reg);
    assign copy_done = !cp_issue && !cp_pend_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign old_len = CW'(old_end_reg) - CW'(off_reg) + CW'(1);
    assign new_end = AW'(CW'(start_reg) + len_reg - CW'(1));

    ffba_mem #(
        .DEPTH(MEM_BYTES),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .st_we(st_we),
        .st_waddr(st_waddr),
        .st_wdata(st_wdata),
        .st_raddr(st_raddr),
        .st_rdata(st_rdata),
        .dt_we(dt_we),
        .dt_waddr(dt_waddr),
        .dt_wdata(dt_wdata),
        .dt_raddr(dt_raddr),
        .dt_rdata(dt_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (ptr_reg[AW-1:0] == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        CMD_ALLOC:   state_next = in_len_ok ? S_FIT : S_DONE;
                        CMD_FREE:    state_next = in_off_ok ? S_LOC : S_DONE;
                        CMD_REALLOC: state_next = in_off_ok ? S_LOC : S_DONE;
                        CMD_READ:    state_next = in_off_ok ? S_RD : S_DONE;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_LOC:
            begin
                if (loc_hit)
                begin
                    state_next = S_FILL;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_FIT:
            begin
                if (fit_hit)
                begin
                    state_next = (cmd_reg == CMD_ALLOC) ? S_FILL : S_COPY;
                end
                else if (scan_end)
                begin
                    state_next = (cmd_reg == CMD_ALLOC) ? S_DONE : S_FILL;
                end
            end
            S_FILL:
            begin
                if (fill_last)
                begin
                    if (fill_kind_reg == FK_CLEAR_RE && len_ok_reg)
                    begin
                        state_next = S_FIT;
                    end
                    else if (fill_kind_reg == FK_CLEAR_RE)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_COPY:
            begin
                if (copy_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_RD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        ptr_next = ptr_reg;
        pend_next = 1'b0;
        idx_next = ptr_reg[AW-1:0];
        open_next = open_reg;
        hit_next = hit_reg;
        run_next = run_reg;
        st_next = st_reg;
        cmd_next = cmd_reg;
        off_next = off_reg;
        len_next = len_reg;
        len_ok_next = len_ok_reg;
        old_end_next = old_end_reg;
        start_next = start_reg;
        fill_pos_next = fill_pos_reg;
        fill_end_next = fill_end_reg;
        fill_base_next = fill_base_reg;
        fill_mark_next = fill_mark_reg;
        fill_kind_next = fill_kind_reg;
        cp_k_next = cp_k_reg;
        cp_n_next = cp_n_reg;
        cp_pend_next = 1'b0;
        cp_dst_next = cp_dst_reg;
        res_next = res_reg;
        grant_next = grant_reg;
        rdat_next = rdat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next = out_res_reg;
        out_grant_next = out_grant_reg;
        out_rdat_next = out_rdat_reg;

        st_we = 1'b0;
        st_waddr = fill_pos_reg;
        st_wdata = ST_FREE;
        st_raddr = ptr_reg[AW-1:0];
        dt_we = 1'b0;
        dt_waddr = cp_dst_reg;
        dt_wdata = dt_rdata;
        dt_raddr = off_reg + cp_k_reg[AW-1:0];

        case (state_reg)
            S_CLR:
            begin
                st_we = 1'b1;
                st_waddr = ptr_reg[AW-1:0];
                st_wdata = ST_FREE;
                dt_we = 1'b1;
                dt_waddr = ptr_reg[AW-1:0];
                dt_wdata = '0;
                ptr_next = ptr_reg + CW'(1);
            end
            S_IDLE:
            begin
                dt_raddr = AW'(in_off);
                if (accept)
                begin
                    cmd_next = in_cmd;
                    off_next = AW'(in_off);
                    len_next = CW'(in_len);
                    len_ok_next = in_len_ok;
                    res_next = RES_OK;
                    grant_next = '0;
                    rdat_next = '0;
                    ptr_next = '0;
                    run_next = '0;
                    open_next = 1'b0;
                    hit_next = 1'b0;
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if (!in_len_ok)
                            begin
                                res_next = RES_NO_ROOM;
                            end
                        end
                        CMD_FREE, CMD_REALLOC, CMD_READ:
                        begin
                            if (!in_off_ok)
                            begin
                                res_next = RES_BAD_OFF;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (in_off_ok)
                            begin
                                dt_we = 1'b1;
                                dt_waddr = AW'(in_off);
                                dt_wdata = in_wdat;
                            end
                            else
                            begin
                                res_next = RES_BAD_OFF;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOC:
            begin
                if (scan_issue)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                pend_next = scan_issue && !loc_hit && !scan_end;
                if (pend_reg)
                begin
                    if (st_rdata == ST_TAG)
                    begin
                        open_next = !open_reg;
                        if (!open_reg)
                        begin
                            hit_next = (idx_reg == off_reg);
                        end
                    end
                end
                if (loc_hit)
                begin
                    old_end_next = idx_reg;
                    fill_base_next = off_reg;
                    fill_pos_next = off_reg;
                    fill_end_next = idx_reg;
                    fill_mark_next = 1'b0;
                    fill_kind_next = (cmd_reg == CMD_FREE) ? FK_CLEAR_FREE : FK_CLEAR_RE;
                end
                else if (scan_end)
                begin
                    res_next = RES_BAD_OFF;
                end
            end
            S_FIT:
            begin
                if (scan_issue)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                pend_next = scan_issue && !fit_hit && !scan_end;
                if (pend_reg)
                begin
                    if (st_rdata == ST_FREE)
                    begin
                        st_next = fit_start;
                        run_next = run_inc;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (fit_hit)
                begin
                    start_next = fit_start;
                    grant_next = fit_start;
                    fill_base_next = fit_start;
                    fill_pos_next = fit_start;
                    fill_end_next = AW'(CW'(fit_start) + len_reg - CW'(1));
                    fill_mark_next = 1'b1;
                    fill_kind_next = FK_MARK_NEW;
                    cp_k_next = '0;
                    cp_n_next = (old_len < len_reg) ? old_len : len_reg;
                    cp_dst_next = fit_start;
                end
                else if (scan_end)
                begin
                    res_next = RES_NO_ROOM;
                    fill_base_next = off_reg;
                    fill_pos_next = off_reg;
                    fill_end_next = old_end_reg;
                    fill_mark_next = 1'b1;
                    fill_kind_next = FK_MARK_OLD;
                end
            end
            S_FILL:
            begin
                st_we = 1'b1;
                st_waddr = fill_pos_reg;
                if (!fill_mark_reg)
                begin
                    st_wdata = ST_FREE;
                end
                else if (fill_base_reg == fill_end_reg)
                begin
                    st_wdata = ST_SINGLE;
                end
                else if (fill_pos_reg == fill_base_reg || fill_last)
                begin
                    st_wdata = ST_TAG;
                end
                else
                begin
                    st_wdata = ST_INNER;
                end
                fill_pos_next = fill_pos_reg + AW'(1);
                if (fill_last && fill_kind_reg == FK_CLEAR_RE)
                begin
                    ptr_next = '0;
                    run_next = '0;
                    if (!len_ok_reg)
                    begin
                        // Zero or oversize request: put the old block back.
                        res_next = RES_NO_ROOM;
                        fill_pos_next = off_reg;
                        fill_end_next = old_end_reg;
                        fill_mark_next = 1'b1;
                        fill_kind_next = FK_MARK_OLD;
                    end
                end
            end
            S_COPY:
            begin
                // Reads run one byte ahead of writes; the target either starts no higher than
                // the source or does not overlap it, so an ascending copy is safe.
                dt_raddr = off_reg + cp_k_reg[AW-1:0];
                if (cp_issue)
                begin
                    cp_k_next = cp_k_reg + CW'(1);
                end
                cp_pend_next = cp_issue;
                if (cp_pend_reg)
                begin
                    dt_we = 1'b1;
                    dt_waddr = cp_dst_reg;
                    dt_wdata = dt_rdata;
                    cp_dst_next = cp_dst_reg + AW'(1);
                end
                if (copy_done)
                begin
                    fill_base_next = start_reg;
                    fill_pos_next = start_reg;
                    fill_end_next = new_end;
                    fill_mark_next = 1'b1;
                    fill_kind_next = FK_MARK_NEW;
                end
            end
            S_RD:
            begin
                rdat_next = dt_rdata;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next = res_reg;
                    out_grant_next = OFF_W'(grant_reg);
                    out_rdat_next = rdat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ptr_reg <= '0;
            pend_reg <= 1'b0;
            cp_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_kind_reg <= FK_CLEAR_FREE;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            pend_reg <= pend_next;
            cp_pend_reg <= cp_pend_next;
            out_valid_reg <= out_valid_next;
            fill_kind_reg <= fill_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        open_reg <= open_next;
        hit_reg <= hit_next;
        run_reg <= run_next;
        st_reg <= st_next;
        cmd_reg <= cmd_next;
        off_reg <= off_next;
        len_reg <= len_next;
        len_ok_reg <= len_ok_next;
        old_end_reg <= old_end_next;
        start_reg <= start_next;
        fill_pos_reg <= fill_pos_next;
        fill_end_reg <= fill_end_next;
        fill_base_reg <= fill_base_next;
        fill_mark_reg <= fill_mark_next;
        cp_k_reg <= cp_k_next;
        cp_n_reg <= cp_n_next;
        cp_dst_reg <= cp_dst_next;
        res_reg <= res_next;
        grant_reg <= grant_next;
        rdat_reg <= rdat_next;
        out_res_reg <= out_res_next;
        out_grant_reg <= out_grant_next;
        out_rdat_reg <= out_rdat_next;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ffba_pkg::*;

    localparam int NBYTES = 256;

    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] grant;
        logic [1:0] status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    logic [1:0] tag_map [NBYTES];
    logic [7:0] byte_mem [NBYTES];
    answer_t    pending_answers[$];
    int         error_count;
    int         word_count;
    int         answer_count;
    bit         stall_enable;

    first_fit_byte_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Block start search: a tag opens a block when none is open, and closes it otherwise.
    function automatic bit find_block(int off, output int last);
        bit open;
        bit hit;
        open = 0;
        hit = 0;
        last = 0;
        for (int i = 0; i < NBYTES; i++)
        begin
            if (tag_map[i] == ST_SINGLE && !open)
            begin
                if (i == off)
                begin
                    last = i;
                    return 1;
                end
            end
            else if (tag_map[i] == ST_TAG)
            begin
                if (!open)
                begin
                    open = 1;
                    hit = (i == off);
                end
                else
                begin
                    open = 0;
                    if (hit)
                    begin
                        last = i;
                        return 1;
                    end
                end
            end
        end
        return 0;
    endfunction

    function automatic bit lowest_fit(int len, output int start);
        int run;
        run = 0;
        start = 0;
        if (len == 0 || len > NBYTES)
            return 0;
        for (int i = 0; i < NBYTES; i++)
        begin
            if (tag_map[i] == ST_FREE)
            begin
                if (run == 0)
                    start = i;
                run++;
                if (run == len)
                    return 1;
            end
            else
                run = 0;
        end
        return 0;
    endfunction

    function automatic void tag_block(int start, int len);
        if (len == 1)
        begin
            tag_map[start] = ST_SINGLE;
            return;
        end
        for (int i = start + 1; i < start + len - 1; i++)
            tag_map[i] = ST_INNER;
        tag_map[start] = ST_TAG;
        tag_map[start + len - 1] = ST_TAG;
    endfunction

    function automatic void untag_block(int start, int last);
        for (int i = start; i <= last; i++)
            tag_map[i] = ST_FREE;
    endfunction

    function automatic answer_t allocator_answer(logic [2:0] cmd, int off, int len,
                                                 logic [7:0] wdat);
        answer_t a;
        int start;
        int last;
        int old_len;
        int n;
        logic [7:0] tmp [NBYTES];
        a = '0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (lowest_fit(len, start))
                begin
                    tag_block(start, len);
                    a.grant = start[7:0];
                end
                else
                    a.status = RES_NO_ROOM;
            end
            CMD_FREE:
            begin
                if (find_block(off, last))
                    untag_block(off, last);
                else
                    a.status = RES_BAD_OFF;
            end
            CMD_REALLOC:
            begin
                if (!find_block(off, last))
                    a.status = RES_BAD_OFF;
                else
                begin
                    old_len = last - off + 1;
                    untag_block(off, last);
                    if (lowest_fit(len, start))
                    begin
                        n = (old_len < len) ? old_len : len;
                        tmp = byte_mem;
                        for (int i = 0; i < n; i++)
                            byte_mem[start + i] = tmp[off + i];
                        tag_block(start, len);
                        a.grant = start[7:0];
                    end
                    else
                    begin
                        tag_block(off, old_len);
                        a.status = RES_NO_ROOM;
                    end
                end
            end
            CMD_WRITE: byte_mem[off] = wdat;
            CMD_READ: a.rdata = byte_mem[off];
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on answer %0d: %s got %0d expected %0d",
                 answer_count, what, got, want);
        error_count++;
    endtask

    // The valid line stays high after a word so that words can follow back to back.
    task automatic send_command(logic [2:0] cmd, int off, int len, logic [7:0] wdat);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tdata <= {4'd0, wdat, len[8:0], off[7:0], cmd};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_answers.push_back(allocator_answer(cmd, off, len, wdat));
        word_count++;
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[17:0];
            if (pending_answers.size() == 0)
            begin
                $display("unexpected answer word %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.grant !== want.grant)
                    report_mismatch("granted offset", got.grant, want.grant);
                if (got.rdata !== want.rdata)
                    report_mismatch("read byte", got.rdata, want.rdata);
            end
            answer_count++;
        end
    end

    // Receiver stalls: mostly ready, sometimes short or long holds.
    initial
    begin
        int g;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_command(CMD_ALLOC, 0, 0, 0);
        send_command(CMD_ALLOC, 0, 257, 0);
        send_command(CMD_ALLOC, 0, 256, 0);
        send_command(CMD_ALLOC, 0, 1, 0);
        send_command(CMD_FREE, 0, 0, 0);
        send_command(CMD_ALLOC, 0, 1, 0);
        send_command(CMD_ALLOC, 0, 5, 0);
        send_command(CMD_ALLOC, 0, 2, 0);
        send_command(CMD_WRITE, 1, 0, 8'hff);
        send_command(CMD_WRITE, 255, 0, 8'ha5);
        send_command(CMD_READ, 255, 0, 0);
        send_command(CMD_FREE, 3, 0, 0);
        send_command(CMD_FREE, 255, 0, 0);
        send_command(CMD_REALLOC, 1, 3, 0);
        send_command(CMD_REALLOC, 7, 0, 0);
        send_command(CMD_REALLOC, 0, 300, 0);
        send_command(CMD_REALLOC, 0, 1, 0);
        send_command(3'd5, 9, 9, 9);
        send_command(3'd7, 255, 511, 255);
        send_command(CMD_ALLOC, 0, 249, 0);
        send_command(CMD_READ, 0, 0, 0);
        send_command(CMD_ALLOC, 0, 511, 0);
    endtask

    task automatic test_free_all();
        int last;
        for (int i = 0; i < NBYTES; i++)
            if (find_block(i, last))
                send_command(CMD_FREE, i, 0, 0);
    endtask

    function automatic int random_start();
        int last;
        int starts[$];
        for (int i = 0; i < NBYTES; i++)
            if (find_block(i, last))
                starts.push_back(i);
        if (starts.size() == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 255);
        return starts[$urandom_range(0, starts.size() - 1)];
    endfunction

    task automatic test_random(int count);
        int r;
        int len;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(1, 24);
            if (r < 30)
                send_command(CMD_ALLOC, $urandom_range(0, 255), len,
                             8'($urandom_range(0, 255)));
            else if (r < 50)
                send_command(CMD_FREE, random_start(), $urandom_range(0, 511), 0);
            else if (r < 65)
                send_command(CMD_REALLOC, random_start(), len, 8'($urandom_range(0, 255)));
            else if (r < 80)
                send_command(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 511),
                             8'($urandom_range(0, 255)));
            else if (r < 97)
                send_command(CMD_READ, $urandom_range(0, 255), 0, 0);
            else
                send_command(3'($urandom_range(5, 7)), $urandom_range(0, 255),
                             $urandom_range(0, 511), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int w;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stall_enable = 0;
        error_count = 0;
        word_count = 0;
        answer_count = 0;
        for (int i = 0; i < NBYTES; i++)
        begin
            tag_map[i] = ST_FREE;
            byte_mem[i] = 8'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        stall_enable = 1;
        test_random(550);
        test_free_all();
        test_random(550);
        stall_enable = 0;
        test_random(50);
        s_tvalid <= 1'b0;
        w = 0;
        while (pending_answers.size() != 0 && w < 200000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (1100) @(posedge clk);
        $display("sent %0d command words and checked %0d answers", word_count, answer_count);
        $display("covered alloc, free, realloc, byte access and unused codes");
        if (error_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule

### files.f
rtl/ffba_pkg.sv
rtl/ffba_mem.sv
rtl/first_fit_byte_allocator.sv
dv/tb.sv
